### sv/assert_macros.svh
// Assertion macros used by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(label, clk, rst_n, cond, conseq, msg)
`endif
`endif

### sv/rdte_pkg.sv
// Shared types and constants of the record deframer.
`timescale 1ns / 1ps
package rdte_pkg;

    localparam int unsigned TAG_W  = 10;
    localparam int unsigned LEN_W  = 32;
    localparam int unsigned UNIT_W = 16;
    localparam int unsigned KIND_W = 3;

    localparam logic [TAG_W-1:0] TEXT_TAG_RESET = 10'd67;
    localparam logic [3:0]       SKIP_LEN       = 4'd14;
    localparam logic [11:0]      LEN_EXTENDED   = 12'hfff;
    localparam logic [UNIT_W-1:0] UNIT_TAB      = 16'd9;

    // Result kinds
    localparam logic [KIND_W-1:0] K_HEADER   = 3'd0;
    localparam logic [KIND_W-1:0] K_TEXT     = 3'd1;
    localparam logic [KIND_W-1:0] K_ZERO_LEN = 3'd2;
    localparam logic [KIND_W-1:0] K_TRUNC    = 3'd3;
    localparam logic [KIND_W-1:0] K_OVERRUN  = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_beat;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag_id;
        logic [TAG_W-1:0]  level;
        logic [LEN_W-1:0]  record_length;
        logic [UNIT_W-1:0] code_unit;
    } t_result;

    typedef struct packed {
        logic    emit;
        t_result res;
    } t_step_out;

endpackage

### sv/rdte_in_if.sv
// Input byte channel of the record deframer.
`timescale 1ns / 1ps
interface rdte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

### sv/rdte_out_if.sv
// Result channel of the record deframer.
`timescale 1ns / 1ps
interface rdte_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [9:0]  tag_id;
    logic [9:0]  level;
    logic [31:0] record_length;
    logic [15:0] code_unit;

    modport source (output valid, output kind, output tag_id, output level,
                    output record_length, output code_unit, input ready);
    modport sink   (input valid, input kind, input tag_id, input level,
                    input record_length, input code_unit, output ready);
endinterface

### sv/rdte_in_stage.sv
// Input register of the record deframer.
`timescale 1ns / 1ps
module rdte_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rdte_pkg::t_in_beat i_beat,
    input  logic              i_take,
    output logic              o_ready,
    output logic              o_valid,
    output rdte_pkg::t_in_beat o_beat
);

    logic               r_valid;
    rdte_pkg::t_in_beat r_beat;

    // Accept a new beat when empty or when the held beat leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load payload on accept
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

### sv/rdte_deframe.sv
// Record framing state, text unit filter and result formation.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rdte_deframe (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rdte_pkg::TAG_W-1:0]          i_cfg_data,
    input  logic                                i_step,
    input  rdte_pkg::t_in_beat                  i_beat,
    output rdte_pkg::t_step_out                 o_step
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_EXTLEN,
        PH_PAYLOAD
    } t_phase;

    t_phase                         r_phase, n_phase;
    logic [1:0]                     r_byte_index, n_byte_index;
    logic [31:0]                    r_header_shift, n_header_shift;
    logic [rdte_pkg::LEN_W-1:0]     r_remaining, n_remaining;
    logic                           r_in_text, n_in_text;
    logic                           r_hold_valid, n_hold_valid;
    logic [7:0]                     r_hold_byte, n_hold_byte;
    logic [3:0]                     r_skip_count, n_skip_count;
    logic                           r_halted, n_halted;
    logic [rdte_pkg::TAG_W-1:0]     r_cur_tag, n_cur_tag;
    logic [rdte_pkg::TAG_W-1:0]     r_cur_level, n_cur_level;
    logic [rdte_pkg::LEN_W-1:0]     r_cur_len, n_cur_len;
    logic [rdte_pkg::TAG_W-1:0]     r_text_tag;

    logic [31:0]                    hs_shift;
    logic [rdte_pkg::LEN_W-1:0]     rem_dec;
    logic [rdte_pkg::UNIT_W-1:0]    unit;
    logic [11:0]                    len12;
    rdte_pkg::t_step_out            step;

    // Control units that make the next 14 payload bytes be skipped
    function automatic logic f_is_skip(input logic [rdte_pkg::UNIT_W-1:0] u);
        logic r;
        r = 1'b0;
        if (u[15:5] == 11'd0) begin
            case (u[4:0]) inside
                [5'd1:5'd9], 5'd11, 5'd12, [5'd14:5'd23]: r = 1'b1;
                default: r = 1'b0;
            endcase
        end
        return r;
    endfunction

    assign hs_shift = {i_beat.data_byte, r_header_shift[31:8]};
    assign rem_dec  = r_remaining - {31'd0, (r_remaining != '0)};
    assign unit     = {i_beat.data_byte, r_hold_byte};
    assign len12    = hs_shift[31:20];

    // Advance the framing state by one beat
    always_comb begin
        n_phase        = r_phase;
        n_byte_index   = r_byte_index;
        n_header_shift = r_header_shift;
        n_remaining    = r_remaining;
        n_in_text      = r_in_text;
        n_hold_valid   = r_hold_valid;
        n_hold_byte    = r_hold_byte;
        n_skip_count   = r_skip_count;
        n_halted       = r_halted;
        n_cur_tag      = r_cur_tag;
        n_cur_level    = r_cur_level;
        n_cur_len      = r_cur_len;
        step           = '0;
        step.res.tag_id        = r_cur_tag;
        step.res.level         = r_cur_level;
        step.res.record_length = r_cur_len;

        if (i_step && !r_halted) begin
            if (i_beat.stream_end) begin
                // Flag a header cut short, then restart the stream
                if (r_phase == PH_EXTLEN) begin
                    step.emit              = 1'b1;
                    step.res.kind          = rdte_pkg::K_TRUNC;
                    step.res.record_length = '0;
                end else if (r_phase != PH_PAYLOAD && r_byte_index != 2'd0) begin
                    step.emit     = 1'b1;
                    step.res.kind = rdte_pkg::K_TRUNC;
                    step.res.tag_id        = '0;
                    step.res.level         = '0;
                    step.res.record_length = '0;
                end
                n_phase        = PH_HEADER;
                n_byte_index   = 2'd0;
                n_header_shift = '0;
                n_remaining    = '0;
                n_in_text      = 1'b0;
                n_hold_valid   = 1'b0;
                n_hold_byte    = '0;
                n_skip_count   = '0;
                n_cur_tag      = '0;
                n_cur_level    = '0;
                n_cur_len      = '0;
            end else begin
                unique case (r_phase)
                    PH_PAYLOAD: begin
                        n_remaining = rem_dec;
                        if (r_in_text) begin
                            if (r_skip_count != 4'd0) begin
                                n_skip_count = r_skip_count - 4'd1;
                            end else if (r_hold_valid) begin
                                n_hold_valid = 1'b0;
                                n_hold_byte  = '0;
                                if (f_is_skip(unit)) begin
                                    // Clip the skip at the record end
                                    if (rem_dec < {28'd0, rdte_pkg::SKIP_LEN}) begin
                                        n_skip_count       = rem_dec[3:0];
                                        step.emit          = 1'b1;
                                        step.res.kind      = rdte_pkg::K_OVERRUN;
                                        step.res.code_unit = unit;
                                    end else begin
                                        n_skip_count = rdte_pkg::SKIP_LEN;
                                        if (unit == rdte_pkg::UNIT_TAB) begin
                                            step.emit          = 1'b1;
                                            step.res.kind      = rdte_pkg::K_TEXT;
                                            step.res.code_unit = rdte_pkg::UNIT_TAB;
                                        end
                                    end
                                end else if (unit[15:5] != 11'd0) begin
                                    step.emit          = 1'b1;
                                    step.res.kind      = rdte_pkg::K_TEXT;
                                    step.res.code_unit = unit;
                                end
                            end else begin
                                n_hold_valid = 1'b1;
                                n_hold_byte  = i_beat.data_byte;
                            end
                        end
                        // Close the record on its last byte
                        if (rem_dec == '0) begin
                            n_phase      = PH_HEADER;
                            n_in_text    = 1'b0;
                            n_hold_valid = 1'b0;
                            n_hold_byte  = '0;
                            n_skip_count = '0;
                        end
                    end
                    PH_EXTLEN: begin
                        n_header_shift = hs_shift;
                        n_byte_index   = r_byte_index + 2'd1;
                        if (r_byte_index == 2'd3) begin
                            n_cur_len      = hs_shift;
                            n_remaining    = hs_shift;
                            n_in_text      = (r_cur_tag == r_text_tag);
                            n_hold_valid   = 1'b0;
                            n_hold_byte    = '0;
                            n_skip_count   = '0;
                            n_header_shift = '0;
                            n_phase        = (hs_shift != '0) ? PH_PAYLOAD : PH_HEADER;
                            step.emit              = 1'b1;
                            step.res.kind          = rdte_pkg::K_HEADER;
                            step.res.record_length = hs_shift;
                        end
                    end
                    default: begin
                        n_phase        = PH_HEADER;
                        n_header_shift = hs_shift;
                        n_byte_index   = r_byte_index + 2'd1;
                        if (r_byte_index == 2'd3) begin
                            n_cur_tag   = hs_shift[9:0];
                            n_cur_level = hs_shift[19:10];
                            step.res.tag_id = hs_shift[9:0];
                            step.res.level  = hs_shift[19:10];
                            if (len12 == 12'd0) begin
                                // Halt on a zero length record
                                n_cur_len      = '0;
                                n_halted       = 1'b1;
                                n_header_shift = '0;
                                step.emit              = 1'b1;
                                step.res.kind          = rdte_pkg::K_ZERO_LEN;
                                step.res.record_length = '0;
                            end else if (len12 == rdte_pkg::LEN_EXTENDED) begin
                                n_header_shift = '0;
                                n_phase        = PH_EXTLEN;
                            end else begin
                                n_cur_len      = {20'd0, len12};
                                n_remaining    = {20'd0, len12};
                                n_in_text      = (hs_shift[9:0] == r_text_tag);
                                n_hold_valid   = 1'b0;
                                n_hold_byte    = '0;
                                n_skip_count   = '0;
                                n_header_shift = '0;
                                n_phase        = PH_PAYLOAD;
                                step.emit              = 1'b1;
                                step.res.kind          = rdte_pkg::K_HEADER;
                                step.res.record_length = {20'd0, len12};
                            end
                        end
                    end
                endcase
            end
        end
    end

    assign o_step = step;

    // Hold framing state and the text tag register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_byte_index   <= 2'd0;
            r_header_shift <= '0;
            r_remaining    <= '0;
            r_in_text      <= 1'b0;
            r_hold_valid   <= 1'b0;
            r_hold_byte    <= '0;
            r_skip_count   <= '0;
            r_halted       <= 1'b0;
            r_cur_tag      <= '0;
            r_cur_level    <= '0;
            r_cur_len      <= '0;
            r_text_tag     <= rdte_pkg::TEXT_TAG_RESET;
        end else begin
            r_phase        <= n_phase;
            r_byte_index   <= n_byte_index;
            r_header_shift <= n_header_shift;
            r_remaining    <= n_remaining;
            r_in_text      <= n_in_text;
            r_hold_valid   <= n_hold_valid;
            r_hold_byte    <= n_hold_byte;
            r_skip_count   <= n_skip_count;
            r_halted       <= n_halted;
            r_cur_tag      <= n_cur_tag;
            r_cur_level    <= n_cur_level;
            r_cur_len      <= n_cur_len;
            if (i_cfg_we) begin
                r_text_tag <= i_cfg_data;
            end
        end
    end

    `ASSERT_IMPLY(a_halted_silent, i_clk, i_rst_n, r_halted, !step.emit, "result while halted")
    `ASSERT_CLK(a_skip_bound, i_clk, i_rst_n, r_skip_count <= rdte_pkg::SKIP_LEN, "skip too long")
    `ASSERT_IMPLY(a_payload_left, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_remaining != '0, "empty payload phase")
    `ASSERT_IMPLY(a_skip_in_text, i_clk, i_rst_n, r_skip_count != 4'd0, r_in_text && r_phase == PH_PAYLOAD, "skip outside text")
    `ASSERT_IMPLY(a_hold_in_text, i_clk, i_rst_n, r_hold_valid, r_in_text, "held byte outside text")

endmodule

### sv/rdte_out_stage.sv
// Result register of the record deframer.
`timescale 1ns / 1ps
module rdte_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  rdte_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output rdte_pkg::t_result o_res
);

    logic              r_valid;
    rdte_pkg::t_result r_res;

    // Free when empty or when the held beat is taken this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Capture a new result
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### sv/record_deframer_text_extract.sv
// A byte held in the input register steps rdte_deframe when the result register has room.
// Throughput: one byte per cycle unless stalled; the framing state updates once per beat.
// Results leave through a one-entry output register; input is held while it is stalled.
// Reset (i_rst_n low, synchronous): framing state cleared, halt released, text tag 67.
// A zero length header halts the block until the next reset.
`timescale 1ns / 1ps
module record_deframer_text_extract (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rdte_pkg::TAG_W-1:0]   i_cfg_data,
    rdte_in_if.sink                      i_in,
    rdte_out_if.source                   o_out
);

    rdte_pkg::t_in_beat  in_beat;
    rdte_pkg::t_in_beat  held_beat;
    rdte_pkg::t_step_out step;
    rdte_pkg::t_result   out_res;
    logic                held_valid;
    logic                out_free;
    logic                take;

    assign in_beat.data_byte  = i_in.data_byte;
    assign in_beat.stream_end = i_in.stream_end;

    // Move the held beat through the deframer when the result side has room
    assign take = held_valid && out_free;

    rdte_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_beat  (in_beat),
        .i_take  (take),
        .o_ready (i_in.ready),
        .o_valid (held_valid),
        .o_beat  (held_beat)
    );

    rdte_deframe u_deframe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_step     (take),
        .i_beat     (held_beat),
        .o_step     (step)
    );

    rdte_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && step.emit),
        .i_res   (step.res),
        .i_ready (o_out.ready),
        .o_free  (out_free),
        .o_valid (o_out.valid),
        .o_res   (out_res)
    );

    assign o_out.kind          = out_res.kind;
    assign o_out.tag_id        = out_res.tag_id;
    assign o_out.level         = out_res.level;
    assign o_out.record_length = out_res.record_length;
    assign o_out.code_unit     = out_res.code_unit;

endmodule

### dv/tb_record_deframer_text_extract.sv
// Self-checking testbench of the record deframer: directed and random byte streams, scored.
`timescale 1ns / 1ps
module tb_record_deframer_text_extract;

    localparam int unsigned PHASE_ITEMS     = 285;
    localparam int unsigned LATENCY_PAD     = 4;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned WATCHDOG_LIMIT  = 3000;

    typedef enum logic [1:0] {FR_HEADER, FR_EXTLEN, FR_PAYLOAD} t_frame_phase;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [rdte_pkg::TAG_W-1:0] cfg_data = '0;

    rdte_in_if  in_if();
    rdte_out_if out_if();

    // Sender and receiver drive the channels through these
    logic               send_valid = 1'b0;
    rdte_pkg::t_in_beat send_beat  = '0;
    logic               recv_ready = 1'b0;
    logic               in_fire    = 1'b0;

    assign in_if.valid      = send_valid;
    assign in_if.data_byte  = send_beat.data_byte;
    assign in_if.stream_end = send_beat.stream_end;
    assign out_if.ready     = recv_ready;

    record_deframer_text_extract i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    rdte_pkg::t_in_beat beat_queue[$];
    rdte_pkg::t_result  expected_results[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_off_asked = 0;
    int unsigned hold_off_taken = 0;
    int unsigned hold_off_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned fail_count = 0;
    logic [rdte_pkg::TAG_W-1:0] gen_text_tag = rdte_pkg::TEXT_TAG_RESET;

    // Deframer state as predicted from the accepted beats
    t_frame_phase               fr_phase;
    logic [1:0]                 fr_idx;
    logic [31:0]                fr_shift;
    logic [31:0]                fr_remain;
    logic                       fr_text;
    logic                       fr_hold_vld;
    logic [7:0]                 fr_hold;
    logic [3:0]                 fr_skip;
    logic                       fr_halted;
    logic [rdte_pkg::TAG_W-1:0] fr_tag;
    logic [rdte_pkg::TAG_W-1:0] fr_level;
    logic [rdte_pkg::LEN_W-1:0] fr_len;
    logic [rdte_pkg::TAG_W-1:0] fr_text_tag;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic rdte_pkg::t_result make_result(
            input logic [rdte_pkg::KIND_W-1:0] kind,
            input logic [rdte_pkg::UNIT_W-1:0] cu);
        rdte_pkg::t_result r;
        r.kind          = kind;
        r.tag_id        = fr_tag;
        r.level         = fr_level;
        r.record_length = fr_len;
        r.code_unit     = cu;
        return r;
    endfunction

    function void frame_clear();
        fr_phase    = FR_HEADER;
        fr_idx      = '0;
        fr_shift    = '0;
        fr_remain   = '0;
        fr_text     = 1'b0;
        fr_hold_vld = 1'b0;
        fr_hold     = '0;
        fr_skip     = '0;
        fr_tag      = '0;
        fr_level    = '0;
        fr_len      = '0;
    endfunction

    function void record_open(input logic [31:0] len);
        fr_len      = len;
        fr_remain   = len;
        fr_text     = (fr_tag == fr_text_tag);
        fr_hold_vld = 1'b0;
        fr_skip     = '0;
        fr_shift    = '0;
        fr_idx      = '0;
        fr_phase    = (len != 32'd0) ? FR_PAYLOAD : FR_HEADER;
    endfunction

    // Shift one header byte in from the top; report a complete word
    function logic shift_byte(input logic [7:0] b);
        fr_shift = {b, fr_shift[31:8]};
        fr_idx   = fr_idx + 2'd1;
        return fr_idx == 2'd0;
    endfunction

    // Classify one UTF-16 unit of a text record
    function void filter_unit(input logic [15:0] u, output logic hit,
                              output rdte_pkg::t_result r);
        logic skips;
        skips = (u >= 16'd1 && u <= 16'd9) || u == 16'd11 || u == 16'd12 ||
                (u >= 16'd14 && u <= 16'd23);
        hit = 1'b0;
        r   = '0;
        if (skips) begin
            if (fr_remain < 32'(rdte_pkg::SKIP_LEN)) begin
                // clip the skip at the record end and flag it
                fr_skip = fr_remain[3:0];
                hit     = 1'b1;
                r       = make_result(rdte_pkg::K_OVERRUN, u);
            end else begin
                fr_skip = rdte_pkg::SKIP_LEN;
                if (u == rdte_pkg::UNIT_TAB) begin
                    hit = 1'b1;
                    r   = make_result(rdte_pkg::K_TEXT, rdte_pkg::UNIT_TAB);
                end
            end
        end else if (u >= 16'd32) begin
            hit = 1'b1;
            r   = make_result(rdte_pkg::K_TEXT, u);
        end
    endfunction

    // Advance the predicted state by one input beat
    function void predict_beat(input rdte_pkg::t_in_beat bt, output logic hit,
                               output rdte_pkg::t_result r);
        logic [15:0] u;
        logic [11:0] len12;
        hit = 1'b0;
        r   = '0;
        if (fr_halted)
            return;
        if (bt.stream_end) begin
            if (fr_phase == FR_EXTLEN) begin
                fr_len = '0;
                hit    = 1'b1;
                r      = make_result(rdte_pkg::K_TRUNC, '0);
            end else if (fr_phase != FR_PAYLOAD && fr_idx != 2'd0) begin
                fr_tag   = '0;
                fr_level = '0;
                fr_len   = '0;
                hit      = 1'b1;
                r        = make_result(rdte_pkg::K_TRUNC, '0);
            end
            frame_clear();
            return;
        end
        case (fr_phase)
            FR_PAYLOAD: begin
                if (fr_remain != 32'd0)
                    fr_remain = fr_remain - 32'd1;
                if (fr_text) begin
                    if (fr_skip != 4'd0) begin
                        fr_skip = fr_skip - 4'd1;
                    end else if (fr_hold_vld) begin
                        u           = {bt.data_byte, fr_hold};
                        fr_hold_vld = 1'b0;
                        filter_unit(u, hit, r);
                    end else begin
                        fr_hold_vld = 1'b1;
                        fr_hold     = bt.data_byte;
                    end
                end
                if (fr_remain == 32'd0) begin
                    fr_phase    = FR_HEADER;
                    fr_text     = 1'b0;
                    fr_hold_vld = 1'b0;
                    fr_skip     = '0;
                end
            end
            FR_EXTLEN: begin
                if (shift_byte(bt.data_byte)) begin
                    record_open(fr_shift);
                    hit = 1'b1;
                    r   = make_result(rdte_pkg::K_HEADER, '0);
                end
            end
            default: begin
                if (shift_byte(bt.data_byte)) begin
                    fr_tag   = fr_shift[9:0];
                    fr_level = fr_shift[19:10];
                    len12    = fr_shift[31:20];
                    if (len12 == 12'd0) begin
                        fr_len    = '0;
                        fr_halted = 1'b1;
                        fr_shift  = '0;
                        hit       = 1'b1;
                        r         = make_result(rdte_pkg::K_ZERO_LEN, '0);
                    end else if (len12 == rdte_pkg::LEN_EXTENDED) begin
                        fr_shift = '0;
                        fr_phase = FR_EXTLEN;
                    end else begin
                        record_open({20'd0, len12});
                        hit = 1'b1;
                        r   = make_result(rdte_pkg::K_HEADER, '0);
                    end
                end
            end
        endcase
    endfunction

    function void check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            fail_count++;
        end
    endfunction

    // Predict on accepted input beats, score accepted result beats, watch for hangs
    always @(posedge i_clk) begin
        logic               hit;
        rdte_pkg::t_result  exp_r;
        rdte_pkg::t_in_beat got_b;
        if (!i_rst_n) begin
            frame_clear();
            fr_halted   = 1'b0;
            fr_text_tag = rdte_pkg::TEXT_TAG_RESET;
            idle_cycles = 0;
            in_fire    <= 1'b0;
        end else begin
            in_fire <= in_if.valid && in_if.ready;
            if (cfg_we)
                fr_text_tag = cfg_data;
            if (in_if.valid && in_if.ready) begin
                got_b.data_byte  = in_if.data_byte;
                got_b.stream_end = in_if.stream_end;
                predict_beat(got_b, hit, exp_r);
                if (hit)
                    expected_results.push_back(exp_r);
            end
            if (out_if.valid && out_if.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: kind %0d tag %0d level %0d",
                             $time, out_if.kind, out_if.tag_id, out_if.level);
                    $display("%0t: unexpected result: len 0x%0h unit 0x%0h",
                             $time, out_if.record_length, out_if.code_unit);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("kind", 32'(exp_r.kind), 32'(out_if.kind));
                    check_field("tag_id", 32'(exp_r.tag_id), 32'(out_if.tag_id));
                    check_field("level", 32'(exp_r.level), 32'(out_if.level));
                    check_field("record_length", exp_r.record_length,
                                out_if.record_length);
                    check_field("code_unit", 32'(exp_r.code_unit), 32'(out_if.code_unit));
                end
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog: no beat accepted in %0d cycles", $time, idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Offer the next pending beat, hold it until accepted, idle at random
    always @(negedge i_clk) begin
        if (!send_valid || in_fire) begin
            if (beat_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                send_beat  <= beat_queue.pop_front();
                send_valid <= 1'b1;
            end else begin
                send_valid <= 1'b0;
            end
        end
    end

    // Accept results, stall at random or for a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off_left != 0) begin
            hold_off_left = hold_off_left - 1;
            recv_ready   <= 1'b0;
        end else if (hold_off_taken != hold_off_asked) begin
            hold_off_taken = hold_off_asked;
            hold_off_left  = HOLD_OFF_CYCLES;
            recv_ready    <= 1'b0;
        end else begin
            recv_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_byte(input logic [7:0] b);
        rdte_pkg::t_in_beat bt;
        bt.data_byte  = b;
        bt.stream_end = 1'b0;
        beat_queue.push_back(bt);
    endtask

    task automatic push_end();
        rdte_pkg::t_in_beat bt;
        bt.data_byte  = 8'($urandom);
        bt.stream_end = 1'b1;
        beat_queue.push_back(bt);
    endtask

    task automatic push_header(input logic [9:0] tag, input logic [9:0] lvl,
                               input logic [11:0] len12);
        logic [31:0] word;
        word = {len12, lvl, tag};
        for (int i = 0; i < 4; i++)
            push_byte(word[8*i +: 8]);
    endtask

    // Queue one record; a cut record ends the stream partway through its payload
    task automatic emit_record(input logic [9:0] tag, input logic [9:0] lvl,
                               input logic [31:0] len, input bit ext, input bit cut);
        logic [7:0]  pl[$];
        logic [15:0] u;
        int unsigned n;
        int unsigned pick;
        push_header(tag, lvl, ext ? rdte_pkg::LEN_EXTENDED : len[11:0]);
        if (ext)
            for (int i = 0; i < 4; i++)
                push_byte(len[8*i +: 8]);
        n = (len > 32'd200) ? 200 : len;
        if (cut)
            n = (n == 0) ? 0 : $urandom_range(0, ((n > 40) ? 40 : n) - 1);
        while (pl.size() < n) begin
            if (tag == gen_text_tag) begin
                pick = $urandom_range(99);
                if (pick < 30)
                    u = 16'($urandom_range(31));
                else if (pick < 42)
                    u = rdte_pkg::UNIT_TAB;
                else if (pick < 80)
                    u = 16'($urandom_range(32, 126));
                else
                    u = 16'($urandom);
                pl.push_back(u[7:0]);
                pl.push_back(u[15:8]);
                // leave room for the bytes a control unit skips
                if (u < 16'd32)
                    repeat (14) pl.push_back(8'($urandom));
            end else begin
                pl.push_back(8'($urandom));
            end
        end
        for (int i = 0; i < int'(n); i++)
            push_byte(pl[i]);
        if (cut)
            push_end();
    endtask

    // Queue a stream of records followed by a clean, broken or missing end
    task automatic gen_stream();
        int unsigned nrec;
        int unsigned pick;
        logic [9:0]  tag;
        logic [31:0] len;
        bit          ext;
        bit          cut;
        nrec = $urandom_range(1, 3);
        for (int k = 0; k < int'(nrec); k++) begin
            tag  = $urandom_range(1) ? gen_text_tag : 10'($urandom);
            pick = $urandom_range(99);
            ext  = 1'b0;
            cut  = ($urandom_range(99) < 8);
            if (pick < 70) begin
                len = $urandom_range(1, 24);
            end else if (pick < 82) begin
                len = $urandom_range(25, 80);
            end else if (pick < 90) begin
                ext = 1'b1;
                len = $urandom_range(0, 30);
            end else if (pick < 94) begin
                ext = 1'b1;
                len = $urandom;
                cut = 1'b1;
            end else if (pick < 96) begin
                len = 32'(rdte_pkg::LEN_EXTENDED) - 32'd1;
                cut = 1'b1;
            end else begin
                len = $urandom_range(1, 12);
            end
            emit_record(tag, 10'($urandom), len, ext, cut);
            if (cut)
                return;
        end
        pick = $urandom_range(99);
        if (pick < 40) begin
            push_end();
        end else if (pick < 60) begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
            push_end();
        end else if (pick < 75) begin
            push_header(10'($urandom), 10'($urandom), rdte_pkg::LEN_EXTENDED);
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
            push_end();
        end
    endtask

    task automatic fill_random(input int unsigned count);
        int unsigned goal;
        goal = beat_queue.size() + count;
        while (beat_queue.size() < goal)
            gen_stream();
    endtask

    // Hold until every beat is sent and every result scored, then let the pipe settle
    task automatic wait_drained();
        while (beat_queue.size() != 0 || send_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    task automatic write_text_tag(input logic [rdte_pkg::TAG_W-1:0] v);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        gen_text_tag = v;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: text units at the extremes and an odd tail byte
        push_header(rdte_pkg::TEXT_TAG_RESET, 10'h3ff, 12'd5);
        push_byte(8'hff);
        push_byte(8'hff);
        push_byte(8'h41);
        push_byte(8'h00);
        push_byte(8'haa);
        // extended length of zero, top tag
        push_header(10'h3ff, 10'h000, rdte_pkg::LEN_EXTENDED);
        repeat (4) push_byte(8'h00);
        // tab unit with no room left to skip
        push_header(rdte_pkg::TEXT_TAG_RESET, 10'h155, 12'd2);
        push_byte(8'(rdte_pkg::UNIT_TAB));
        push_byte(8'h00);
        // stream end in the middle of a header
        push_byte(8'h12);
        push_byte(8'h34);
        push_end();
        wait_drained();

        write_text_tag(10'h3ff);
        send_idle_pct = 33;
        recv_idle_pct = 87;
        fill_random(PHASE_ITEMS);
        wait_drained();

        write_text_tag(10'h000);
        send_idle_pct = 87;
        recv_idle_pct = 33;
        fill_random(PHASE_ITEMS);
        wait_drained();

        // No idling; stall the receiver long enough to back up the input
        write_text_tag(10'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fill_random(PHASE_ITEMS);
        hold_off_asked++;
        wait_drained();

        write_text_tag(rdte_pkg::TEXT_TAG_RESET);
        fill_random(PHASE_ITEMS);
        wait_drained();

        // Zero length halts the block; the beats after it are ignored
        push_end();
        push_header(10'($urandom), 10'($urandom), 12'd0);
        push_byte(8'($urandom));
        push_end();
        wait_drained();

        if (fail_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
